// File: src/axis_deadzone_rescale_top_defines.svh
// Assertion macros shared by the axis deadzone rescale RTL.
`ifndef AXIS_DEADZONE_RESCALE_TOP_DEFINES_SVH
`define AXIS_DEADZONE_RESCALE_TOP_DEFINES_SVH

`ifndef SYNTH
// Check a property on clk, masked while rst is high.
`define ADR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on clk, also during reset.
`define ADR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADR_ASSERT(lbl, prop, msg)
`define ADR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: src/adr_pkg.sv
// Shared types, widths and register codes of the axis deadzone rescale block.
`default_nettype none
package adr_pkg;

  // Field and datapath widths
  localparam int unsigned SMP_W  = 12;
  localparam int unsigned TGT_W  = 16;
  localparam int unsigned PROD_W = SMP_W + TGT_W;
  localparam int unsigned NUM_W  = PROD_W + 1;
  localparam int unsigned DIV_STEPS = NUM_W;

  // Output scale defaults
  localparam int unsigned OUT_MAX_DEF = 4095;
  localparam int unsigned OUT_MID_DEF = 2048;

  // Queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;

  // Configuration port
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam logic [1:0] REG_REST_POINT = 2'd0;
  localparam logic [1:0] REG_DEAD_BAND  = 2'd1;
  localparam logic [1:0] REG_SPAN_FULL  = 2'd2;

  localparam logic [SMP_W-1:0] REST_POINT_RST = 12'd2048;
  localparam logic [SMP_W-1:0] DEAD_BAND_RST  = 12'd0;
  localparam logic [SMP_W-1:0] SPAN_FULL_RST  = 12'd2047;

  typedef struct packed {
    logic [SMP_W-1:0] rest_point;
    logic [SMP_W-1:0] dead_band;
    logic [SMP_W-1:0] span_full;
  } adr_cfg_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic             center;
    logic             neg;
    logic [SMP_W-1:0] delta;
    logic [SMP_W-1:0] usable;
  } adr_item_t;

endpackage
`default_nettype wire

// File: src/adr_front.sv
// Front end: accepts raw samples and classifies them against the configuration.
`default_nettype none
module adr_front
  import adr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire adr_cfg_t         cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [SMP_W-1:0] raw_sample,
  output logic                  push,
  output adr_item_t             push_item,
  input  wire logic             fifo_ready
);

  logic      fr_valid;
  adr_item_t fr_item;
  adr_item_t item_next;
  logic      neg;
  logic [SMP_W-1:0] mag;

  // Classify the incoming sample
  always_comb begin
    neg = raw_sample < cfg.rest_point;
    mag = neg ? (cfg.rest_point - raw_sample) : (raw_sample - cfg.rest_point);
    item_next.neg    = neg;
    item_next.center = (cfg.span_full <= cfg.dead_band) || (mag <= cfg.dead_band);
    item_next.delta  = mag - cfg.dead_band;
    item_next.usable = cfg.span_full - cfg.dead_band;
  end

  // Hold one request until the queue takes it
  assign in_ready  = !fr_valid || fifo_ready;
  assign push      = fr_valid && fifo_ready;
  assign push_item = fr_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fr_valid <= 1'b0;
    end else if (in_ready) begin
      fr_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      fr_item <= item_next;
    end
  end

endmodule
`default_nettype wire

// File: src/adr_fifo.sv
// Short queue that decouples the front end from the divider pipeline.
`default_nettype none
`include "axis_deadzone_rescale_top_defines.svh"
module adr_fifo
  import adr_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire adr_item_t push_item,
  output logic           fifo_ready,
  input  wire logic      pop,
  output logic           pop_valid,
  output adr_item_t      pop_item
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  adr_item_t        entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] cnt;

  assign fifo_ready = cnt < CNT_W'(FIFO_DEPTH);
  assign pop_valid  = cnt != '0;
  assign pop_item   = entries[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + CNT_W'(1);
      end else if (pop && !push) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  `ADR_ASSERT(a_cnt_bound, cnt <= CNT_W'(FIFO_DEPTH), "queue count beyond depth")
  `ADR_ASSERT(a_no_pop_empty, pop |-> cnt != '0, "pop from empty queue")
  `ADR_ASSERT(a_cnt_inc, (push && !pop) |=> cnt == $past(cnt) + CNT_W'(1), "count did not rise")

endmodule
`default_nettype wire

// File: src/adr_back.sv
// Back end: scale multiply, pipelined restoring divider and output offset.
`default_nettype none
`include "axis_deadzone_rescale_top_defines.svh"
module adr_back
  import adr_pkg::*;
#(
  parameter int unsigned OUT_MAX = OUT_MAX_DEF,
  parameter int unsigned OUT_MID = OUT_MID_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pop_valid,
  input  wire adr_item_t        pop_item,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [SMP_W-1:0]      axis_out
);

  localparam logic [TGT_W-1:0] MID_V = TGT_W'(OUT_MID);
  localparam logic [TGT_W-1:0] MAX_V = TGT_W'(OUT_MAX);
  localparam logic [TGT_W-1:0] POS_TGT =
    (OUT_MAX > OUT_MID) ? TGT_W'(OUT_MAX - OUT_MID) : '0;

  logic             adv;
  logic [DIV_STEPS:0] vld;
  logic             center [DIV_STEPS+1];
  logic             neg    [DIV_STEPS+1];
  logic [SMP_W-1:0] dsr    [DIV_STEPS+1];
  logic [SMP_W-1:0] rem    [DIV_STEPS+1];
  logic [NUM_W-1:0] work   [DIV_STEPS+1];

  logic [SMP_W-1:0] rem_next  [DIV_STEPS];
  logic [NUM_W-1:0] work_next [DIV_STEPS];

  logic [TGT_W-1:0]  in_tgt;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  num;

  logic [TGT_W-1:0]  fin_tgt;
  logic [TGT_W-1:0]  sat;
  logic [TGT_W:0]    res;
  logic [TGT_W:0]    clamped;
  logic [SMP_W-1:0]  axis_next;

  // Advance the whole pipeline unless the output is stalled
  assign adv = !out_valid || out_ready;
  assign pop = adv && pop_valid;

  // Scale numerator with half-divisor rounding
  always_comb begin
    in_tgt = pop_item.neg ? MID_V : POS_TGT;
    prod   = PROD_W'(pop_item.delta) * PROD_W'(in_tgt);
    num    = NUM_W'(prod) + NUM_W'(pop_item.usable >> 1);
  end

  // One quotient bit per stage
  always_comb begin
    logic [SMP_W:0] cand;
    logic [SMP_W:0] diff;
    logic           ge;
    for (int k = 0; k < DIV_STEPS; k++) begin
      cand = {rem[k], work[k][NUM_W-1]};
      diff = cand - {1'b0, dsr[k]};
      ge   = cand >= {1'b0, dsr[k]};
      rem_next[k]  = ge ? diff[SMP_W-1:0] : cand[SMP_W-1:0];
      work_next[k] = {work[k][NUM_W-2:0], ge};
    end
  end

  // Saturate, offset from midpoint and clamp
  always_comb begin
    fin_tgt = neg[DIV_STEPS] ? MID_V : POS_TGT;
    sat = (work[DIV_STEPS] > NUM_W'(fin_tgt)) ? fin_tgt : work[DIV_STEPS][TGT_W-1:0];
    res = neg[DIV_STEPS] ? ({1'b0, MID_V} - {1'b0, sat}) : ({1'b0, MID_V} + {1'b0, sat});
    clamped = (res > {1'b0, MAX_V}) ? {1'b0, MAX_V} : res;
    axis_next = center[DIV_STEPS] ? MID_V[SMP_W-1:0] : clamped[SMP_W-1:0];
  end

  // Hold valid bits; drop bubbles only by shifting
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[DIV_STEPS-1:0], pop_valid};
      out_valid <= vld[DIV_STEPS];
    end
  end

  // Shift payload through the stages
  always_ff @(posedge clk) begin
    if (adv) begin
      center[0] <= pop_item.center;
      neg[0]    <= pop_item.neg;
      dsr[0]    <= pop_item.usable;
      rem[0]    <= '0;
      work[0]   <= num;
      for (int k = 0; k < DIV_STEPS; k++) begin
        center[k+1] <= center[k];
        neg[k+1]    <= neg[k];
        dsr[k+1]    <= dsr[k];
        rem[k+1]    <= rem_next[k];
        work[k+1]   <= work_next[k];
      end
      axis_out <= axis_next;
    end
  end

  `ADR_ASSERT_ALWAYS(a_rst_empty, $past(rst) |-> !out_valid, "output valid right after reset")
  `ADR_ASSERT(a_stall_hold, (out_valid && !out_ready) |=> $stable(vld), "pipeline moved in stall")
  `ADR_ASSERT(a_rem_bound, (vld[DIV_STEPS] && !center[DIV_STEPS]) |-> rem[DIV_STEPS] < dsr[DIV_STEPS], "divider remainder not below divisor")

endmodule
`default_nettype wire

// File: src/axis_deadzone_rescale_top.sv
// Top level of the axis deadzone rescale block with its configuration registers.
//
//  channel   direction  handshake            payload
//  input     in         in_valid/in_ready    raw_sample[11:0]
//  output    out        out_valid/out_ready  axis_out[11:0]
//  config    in         psel/penable/pready  paddr[3:0], pwdata/prdata[31:0]
//
// One sample enters per cycle while in_ready is high; a stalled output can hold it off.
// A sample passes the front register, the queue, a multiply stage, 29 divider stages and an output register.
// The divider is pipelined, one quotient bit per stage, so it takes a new sample before the last is through.
// Reset is synchronous: queue and pipeline empty, registers at their defaults.
// A stalled output freezes the pipeline; the four-entry queue and front register absorb
// requests meanwhile before in_ready drops.
`default_nettype none
module axis_deadzone_rescale_top
  import adr_pkg::*;
#(
  parameter int unsigned OUT_MAX = OUT_MAX_DEF,
  parameter int unsigned OUT_MID = OUT_MID_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [SMP_W-1:0]  raw_sample,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [SMP_W-1:0]  axis_out
);

  adr_cfg_t   cfg;
  logic [1:0] reg_idx;
  logic       push;
  adr_item_t  push_item;
  logic       fifo_ready;
  logic       pop;
  logic       pop_valid;
  adr_item_t  pop_item;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rest_point <= REST_POINT_RST;
      cfg.dead_band  <= DEAD_BAND_RST;
      cfg.span_full  <= SPAN_FULL_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_REST_POINT: cfg.rest_point <= pwdata[SMP_W-1:0];
        REG_DEAD_BAND:  cfg.dead_band  <= pwdata[SMP_W-1:0];
        REG_SPAN_FULL:  cfg.span_full  <= pwdata[SMP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (reg_idx)
      REG_REST_POINT: prdata = DATA_W'(cfg.rest_point);
      REG_DEAD_BAND:  prdata = DATA_W'(cfg.dead_band);
      REG_SPAN_FULL:  prdata = DATA_W'(cfg.span_full);
      default:        prdata = '0;
    endcase
  end

  adr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .raw_sample (raw_sample),
    .push       (push),
    .push_item  (push_item),
    .fifo_ready (fifo_ready)
  );

  adr_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .fifo_ready (fifo_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  adr_back #(
    .OUT_MAX (OUT_MAX),
    .OUT_MID (OUT_MID)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .axis_out  (axis_out)
  );

endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the axis deadzone rescale block: scoreboard class and driving tasks.
`timescale 1ns / 100ps

// Predicts the rescaled axis for each accepted sample and checks results in order
class rescale_scoreboard;
  int unsigned      out_mid;
  int unsigned      out_max;
  logic [11:0]      rest_point;
  logic [11:0]      dead_band;
  logic [11:0]      span_full;
  logic [11:0]      expected_axis[$];
  int unsigned      errors;
  int unsigned      n_checked;
  int unsigned      n_centered;

  function new(int unsigned mid, int unsigned top);
    out_mid    = mid;
    out_max    = top;
    rest_point = 12'd2048;
    dead_band  = 12'd0;
    span_full  = 12'd2047;
    errors     = 0;
    n_checked  = 0;
    n_centered = 0;
  endfunction

  // Track a register write; indexes past the list are dropped
  function void set_reg(int unsigned idx, logic [31:0] value);
    case (idx)
      adr_pkg::REG_REST_POINT: rest_point = value[11:0];
      adr_pkg::REG_DEAD_BAND:  dead_band  = value[11:0];
      adr_pkg::REG_SPAN_FULL:  span_full  = value[11:0];
      default: ;
    endcase
  endfunction

  function logic [31:0] reg_value(int unsigned idx);
    case (idx)
      adr_pkg::REG_REST_POINT: return {20'd0, rest_point};
      adr_pkg::REG_DEAD_BAND:  return {20'd0, dead_band};
      adr_pkg::REG_SPAN_FULL:  return {20'd0, span_full};
      default: return 32'd0;
    endcase
  endfunction

  // Deadzone, rescale with round-to-nearest, saturate and clamp
  function logic [11:0] rescale_axis(logic [11:0] smp);
    longint unsigned mid;
    longint unsigned top;
    longint unsigned mag;
    longint unsigned usable;
    longint unsigned target;
    longint unsigned scaled;
    longint unsigned res;
    bit              neg;
    mid = out_mid;
    top = out_max;
    if (span_full <= dead_band) return mid[11:0];
    neg = smp < rest_point;
    mag = neg ? longint'(rest_point) - longint'(smp) : longint'(smp) - longint'(rest_point);
    if (mag <= dead_band) return mid[11:0];
    usable = longint'(span_full) - longint'(dead_band);
    if (neg) begin
      target = mid;
    end else begin
      target = (top > mid) ? top - mid : 0;
    end
    scaled = ((mag - dead_band) * target + usable / 2) / usable;
    if (scaled > target) scaled = target;
    res = neg ? mid - scaled : mid + scaled;
    if (res > top) res = top;
    return res[11:0];
  endfunction

  function void note_sample(logic [11:0] smp);
    expected_axis.push_back(rescale_axis(smp));
  endfunction

  function void check_axis(logic [11:0] got);
    logic [11:0] want;
    if (expected_axis.size() == 0) begin
      $error("axis_out: unexpected result %0d with no request outstanding", got);
      errors++;
      return;
    end
    want = expected_axis.pop_front();
    n_checked++;
    if (want == out_mid[11:0]) n_centered++;
    if (got !== want) begin
      $error("axis_out mismatch: expected %0d, actual %0d", want, got);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_axis.size();
  endfunction
endclass

module tb;
  import adr_pkg::*;

  localparam int unsigned MID        = OUT_MID_DEF;
  localparam int unsigned TOP        = OUT_MAX_DEF;
  localparam int unsigned CYCLE_CAP  = 400000;
  localparam int unsigned RX_HOLD    = 200;
  localparam logic [ADDR_W-1:0] ADDR_REST  = {REG_REST_POINT, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_DEAD  = {REG_DEAD_BAND, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPAN  = {REG_SPAN_FULL, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPARE = 4'd12;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_ready;
  logic [SMP_W-1:0]  raw_sample;
  logic              out_valid;
  logic              out_ready;
  logic [SMP_W-1:0]  axis_out;

  rescale_scoreboard sb = new(MID, TOP);

  bit          tx_busy;
  bit          rx_free;
  bit          rx_hold_req;
  int unsigned cycles;
  int unsigned settings;

  axis_deadzone_rescale_top #(
    .OUT_MAX(TOP),
    .OUT_MID(MID)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .raw_sample(raw_sample),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .axis_out  (axis_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, sb.pending());
      $display("FAIL axis_deadzone_rescale_top");
      $finish;
    end
  end

  // Check results first, then record new requests
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_axis(axis_out);
      if (in_valid && in_ready) sb.note_sample(raw_sample);
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random ready pattern, plus a long hold on request
  initial begin
    int unsigned n;
    out_ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
      end
      n = $urandom_range(1, 12);
      out_ready <= 1'b1;
      repeat (n) @(posedge clk);
      if (!rx_free) begin
        n = pick_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(addr[ADDR_W-1:2], data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read back a register and compare with the tracked copy
  task automatic apb_check(input logic [ADDR_W-1:0] addr, input string name);
    logic [DATA_W-1:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = sb.reg_value(addr[ADDR_W-1:2]);
    if (prdata !== want) begin
      $error("%s readback mismatch: expected %0d, actual %0d", name, want, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_regs();
    apb_check(ADDR_REST, "rest_point");
    apb_check(ADDR_DEAD, "dead_band");
    apb_check(ADDR_SPAN, "span_full");
  endtask

  // Write all three registers with noise in the unused upper bits
  task automatic set_config(input int unsigned rest, input int unsigned dead,
                            input int unsigned span);
    apb_write(ADDR_REST, {20'($urandom_range(0, 1048575)), rest[11:0]});
    apb_write(ADDR_DEAD, {20'($urandom_range(0, 1048575)), dead[11:0]});
    apb_write(ADDR_SPAN, {20'($urandom_range(0, 1048575)), span[11:0]});
    check_regs();
    settings++;
  endtask

  // Offer one request after an optional gap, hold until accepted
  task automatic send_sample(input logic [11:0] v);
    int unsigned gap;
    gap = tx_busy ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      raw_sample <= 12'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    raw_sample <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and drain every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sample near the rest point half the time, full range or at the extremes and dead band edges otherwise
  function automatic logic [11:0] pick_raw();
    int r;
    int reach;
    int v;
    r = $urandom_range(0, 99);
    if (r < 40) return 12'($urandom);
    if (r < 90) begin
      reach = int'(sb.span_full) + int'(sb.dead_band) + 50;
      v = int'(sb.rest_point) + $urandom_range(0, 2 * reach) - reach;
    end else begin
      case ($urandom_range(0, 6))
        0: v = 0;
        1: v = 4095;
        2: v = int'(sb.rest_point);
        3: v = int'(sb.rest_point) + int'(sb.dead_band);
        4: v = int'(sb.rest_point) + int'(sb.dead_band) + 1;
        5: v = int'(sb.rest_point) - int'(sb.dead_band);
        default: v = int'(sb.rest_point) - int'(sb.dead_band) - 1;
      endcase
    end
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // Random register setting: mostly sensible, some arbitrary, some at the edges
  task automatic random_config();
    int unsigned r;
    int unsigned rest;
    int unsigned dead;
    int unsigned span;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      rest = $urandom_range(1024, 3072);
      dead = $urandom_range(0, 400);
      span = $urandom_range(dead + 1, (dead + 2047 > 4095) ? 4095 : dead + 2047);
    end else if (r < 85) begin
      rest = $urandom_range(0, 4095);
      dead = $urandom_range(0, 4095);
      span = $urandom_range(0, 4095);
    end else begin
      rest = $urandom_range(0, 1) ? 4095 : 0;
      dead = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4095);
      span = $urandom_range(0, 1) ? 4095 : dead;
    end
    set_config(rest, dead, span);
  endtask

  initial begin
    int unsigned phase;
    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    in_valid   <= 1'b0;
    raw_sample <= '0;
    tx_busy     = 1'b0;
    rx_free     = 1'b0;
    rx_hold_req = 1'b0;
    settings    = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values, then extremes under the default setting
    check_regs();
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd2048);
    send_sample(12'd2047);
    send_sample(12'd2049);
    send_sample(12'h555);
    send_sample(12'haaa);
    drain();

    // Widest span, rest at zero
    set_config(0, 0, 4095);
    send_sample(12'd0);
    send_sample(12'd1);
    send_sample(12'd4095);
    drain();

    // Rest at the top: deflection only on the negative side
    set_config(4095, 0, 4095);
    send_sample(12'd0);
    send_sample(12'd4094);
    drain();

    // Dead band edges and saturation past the span
    set_config(2048, 100, 1000);
    send_sample(12'd2148);
    send_sample(12'd2149);
    send_sample(12'd1948);
    send_sample(12'd1947);
    send_sample(12'd4095);
    send_sample(12'd0);
    drain();

    // Degenerate span: equal to the dead band, then below it
    set_config(2048, 4095, 4095);
    send_sample(12'd0);
    send_sample(12'd4095);
    drain();
    set_config(1000, 300, 10);
    send_sample(12'd3000);
    drain();

    // Write past the register list must change nothing
    apb_write(ADDR_SPARE, $urandom);
    check_regs();

    // Random phases
    for (phase = 0; phase < 9; phase++) begin
      random_config();
      tx_busy = (phase == 3) || (phase == 6);
      rx_free = (phase == 2);
      if (phase == 6) begin
        // Wait until the receiver has started its long hold
        rx_hold_req = 1'b1;
        while (rx_hold_req) @(posedge clk);
      end
      repeat (50) send_sample(pick_raw());
      drain();
    end
    tx_busy = 1'b0;
    rx_free = 1'b0;

    // Leave room for stray results after the last expected one
    repeat (100) @(posedge clk);
    $display("Checked %0d axis results over %0d register settings (%0d centered).",
             sb.n_checked, settings, sb.n_centered);
    $display("Coverage included dead band edges, degenerate spans, saturation and a long stall.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS axis_deadzone_rescale_top");
    end else begin
      $display("FAIL axis_deadzone_rescale_top");
    end
    $finish;
  end
endmodule
